[hw/rtl/rlbe_pkg.sv]
// shared types and constants for the rgb led chain bit encoder
package rlbe_pkg;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam int COLOR_W = 24;
  localparam int CODE_W  = 16;
  localparam int LATCH_W = 10;
  localparam int LEDS_W  = 7;
  localparam int CFG_W   = 16;
  localparam int BIT_W   = 5;
  localparam int POS_W   = 8;
  localparam int CNT_W   = 9;

  localparam logic [BIT_W-1:0] BITS_PER_LED = 5'd24;
  localparam logic [BIT_W-1:0] TOP_BIT      = 5'd23;

  typedef enum logic [1:0] {
    REG_ONE_CODE    = 2'd0,
    REG_ZERO_CODE   = 2'd1,
    REG_LATCH_WORDS = 2'd2,
    REG_LEDS_IN_USE = 2'd3
  } reg_idx_t;

  localparam logic [LATCH_W-1:0] LATCH_WORDS_RST = 10'd50;
  localparam logic [LEDS_W-1:0]  LEDS_IN_USE_RST = 7'd64;

  typedef struct packed {
    logic                  en;
    logic [COLOR_W-1:0]    data;
  } color_wr_t;

endpackage

[hw/rtl/rlbe_color_store.sv]
// colour memory, one grb word per led, with per-entry valid bits for reset clearing
module rlbe_color_store #(
  parameter int MAX_LEDS = 64,
  parameter int IDX_W    = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rlbe_pkg::color_wr_t       wr,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [rlbe_pkg::COLOR_W-1:0] rd_data
);
  import rlbe_pkg::*;

  logic [COLOR_W-1:0] mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] entry_valid;
  logic [COLOR_W-1:0] rd_q;
  logic               rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

[hw/rtl/rgb_led_chain_bit_encoder_unit.sv]
// top level of the rgb led chain bit encoder
// Takes one item per clock cycle, ticks included, unless a held result stalls s_tready,
// and gives its single result in the cycle after acceptance; the rate is set by the colour
// memory's single read port, read once per colour tick at the current led as counters advance.
// The colour memory clears at reset through per-entry valid bits, so no clearing pass runs.
module rgb_led_chain_bit_encoder_unit #(
  parameter int MAX_LEDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // led_index, green, red, blue
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // compare_value
  output logic        m_tlast,
  output logic [2:0]  m_tuser,   // word_valid, busy_res, accepted
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [rlbe_pkg::CFG_W-1:0] cfg_data
);
  import rlbe_pkg::*;

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

  // configuration
  logic [CODE_W-1:0]  one_code;
  logic [CODE_W-1:0]  zero_code;
  logic [LATCH_W-1:0] latch_words;
  logic [LEDS_W-1:0]  leds_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_code    <= '0;
      zero_code   <= '0;
      latch_words <= LATCH_WORDS_RST;
      leds_in_use <= LEDS_IN_USE_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ONE_CODE:    one_code    <= cfg_data[CODE_W-1:0];
        REG_ZERO_CODE:   zero_code   <= cfg_data[CODE_W-1:0];
        REG_LATCH_WORDS: latch_words <= cfg_data[LATCH_W-1:0];
        REG_LEDS_IN_USE: leds_in_use <= cfg_data[LEDS_W-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic               frame_active, frame_active_next;
  logic [POS_W-1:0]   led_position, led_position_next;
  logic [BIT_W-1:0]   bit_position, bit_position_next;
  logic               in_latch_tail, in_latch_tail_next;
  logic [LATCH_W-1:0] latch_count, latch_count_next;

  // result stage
  logic               res_valid;
  logic               res_use_color;
  logic [BIT_W-1:0]   res_sel;
  logic [CODE_W-1:0]  res_one;
  logic [CODE_W-1:0]  res_zero;
  logic               res_word_valid;
  logic               res_last;
  logic               res_busy;
  logic               res_acc;

  cmd_t               cmd;
  logic [7:0]         led_index;
  logic               accept;
  logic [CNT_W-1:0]   n_eff;
  logic [CNT_W-1:0]   max_cnt;
  logic [CNT_W-1:0]   leds_cnt;
  logic               use_color;
  logic               word_valid;
  logic               last;
  logic               acc;
  logic [BIT_W-1:0]   bit_inc;
  logic [POS_W-1:0]   led_inc;
  logic [LATCH_W:0]   latch_inc;
  logic [COLOR_W-1:0] color;
  color_wr_t          wr;

  assign cmd       = cmd_t'(s_tuser);
  assign led_index = s_tdata[7:0];
  assign s_tready  = !res_valid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign max_cnt  = CNT_W'(MAX_LEDS);
  assign leds_cnt = CNT_W'(leds_in_use);
  assign n_eff    = (leds_cnt > max_cnt) ? max_cnt : leds_cnt;

  always_comb begin
    frame_active_next  = frame_active;
    led_position_next  = led_position;
    bit_position_next  = bit_position;
    in_latch_tail_next = in_latch_tail;
    latch_count_next   = latch_count;
    use_color          = 1'b0;
    word_valid         = 1'b0;
    last               = 1'b0;
    acc                = 1'b0;
    bit_inc            = bit_position + 5'd1;
    led_inc            = led_position + 8'd1;
    latch_inc          = {1'b0, latch_count} + 11'd1;
    case (cmd)
      CMD_SET: begin
        acc = !frame_active && (CNT_W'(led_index) < n_eff);
      end
      CMD_START: begin
        if (!frame_active) begin
          acc                = 1'b1;
          led_position_next  = '0;
          bit_position_next  = '0;
          latch_count_next   = '0;
          in_latch_tail_next = 1'b0;
          if (n_eff != '0 || latch_words != '0) begin
            frame_active_next  = 1'b1;
            in_latch_tail_next = (n_eff == '0);
          end
        end
      end
      CMD_TICK: begin
        if (frame_active) begin
          word_valid = 1'b1;
          if (!in_latch_tail && (CNT_W'(led_position) < n_eff)) begin
            use_color = 1'b1;
            if (bit_inc >= BITS_PER_LED) begin
              bit_position_next = '0;
              led_position_next = led_inc;
            end else begin
              bit_position_next = bit_inc;
            end
            if (CNT_W'(led_position_next) >= n_eff) begin
              if (latch_words == '0) begin
                last               = 1'b1;
                frame_active_next  = 1'b0;
                in_latch_tail_next = 1'b0;
                led_position_next  = '0;
                bit_position_next  = '0;
                latch_count_next   = '0;
              end else begin
                in_latch_tail_next = 1'b1;
                latch_count_next   = '0;
              end
            end
          end else begin
            in_latch_tail_next = 1'b1;
            latch_count_next   = latch_inc[LATCH_W-1:0];
            if (latch_inc >= {1'b0, latch_words}) begin
              last               = 1'b1;
              frame_active_next  = 1'b0;
              in_latch_tail_next = 1'b0;
              led_position_next  = '0;
              bit_position_next  = '0;
              latch_count_next   = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active  <= 1'b0;
      led_position  <= '0;
      bit_position  <= '0;
      in_latch_tail <= 1'b0;
      latch_count   <= '0;
    end else if (accept) begin
      frame_active  <= frame_active_next;
      led_position  <= led_position_next;
      bit_position  <= bit_position_next;
      in_latch_tail <= in_latch_tail_next;
      latch_count   <= latch_count_next;
    end
  end

  // stored as green, red, blue from the top bit down
  assign wr.en   = accept && (cmd == CMD_SET) && acc;
  assign wr.data = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

  rlbe_color_store #(
    .MAX_LEDS (MAX_LEDS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_addr (led_index[IDX_W-1:0]),
    .rd_en   (accept && use_color),
    .rd_addr (led_position[IDX_W-1:0]),
    .rd_data (color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_tready) begin
      res_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_use_color  <= use_color;
      res_sel        <= TOP_BIT - bit_position;
      res_one        <= one_code;
      res_zero       <= zero_code;
      res_word_valid <= word_valid;
      res_last       <= last;
      res_busy       <= frame_active_next;
      res_acc        <= acc;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = !res_use_color ? '0 : (color[res_sel] ? res_one : res_zero);
  assign m_tlast  = res_last;
  assign m_tuser  = {res_acc, res_busy, res_word_valid};

  a_tail_needs_frame: assert property (@(posedge clk) disable iff (rst)
    in_latch_tail |-> frame_active)
    else $error("latch tail without an active frame");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_position < BITS_PER_LED)
    else $error("bit position out of range");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !frame_active |-> (led_position == '0 && bit_position == '0 && latch_count == '0))
    else $error("frame counters not cleared while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_last) |-> (res_word_valid && !res_busy))
    else $error("frame end with frame still running");

  a_acc_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_acc && res_word_valid))
    else $error("item both accepted and produced a word");

endmodule

[sim/rlbe_checker.sv]
// checker for the rgb led chain bit encoder: tracks colours and frame state, compares results
module rlbe_checker #(
  parameter int MAX_LEDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // led_index, green, red, blue
  input  logic [1:0]  s_tuser,   // cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // compare_value
  input  logic        m_tlast,
  input  logic [2:0]  m_tuser,   // word_valid, busy_res, accepted
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [rlbe_pkg::CFG_W-1:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlbe_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] compare_value;
    logic              word_valid;
    logic              frame_last;
    logic              busy;
    logic              accepted;
  } led_word_t;

  led_word_t expected_words[$];

  logic [COLOR_W-1:0] colors [MAX_LEDS];
  logic               frame_on;
  logic               tail_on;
  logic [LEDS_W-1:0]  led_at;
  logic [BIT_W-1:0]   bit_at;
  logic [LATCH_W-1:0] tail_count;

  logic [CODE_W-1:0]  one_code;
  logic [CODE_W-1:0]  zero_code;
  logic [LATCH_W-1:0] latch_words;
  logic [LEDS_W-1:0]  leds_in_use;

  function automatic void stop_frame();
    frame_on   = 1'b0;
    tail_on    = 1'b0;
    led_at     = '0;
    bit_at     = '0;
    tail_count = '0;
  endfunction

  function automatic led_word_t encode_item(cmd_t op, logic [31:0] payload);
    led_word_t         w;
    logic [7:0]        idx;
    logic [LEDS_W-1:0] n;
    logic              bit_val;
    w   = '0;
    idx = payload[7:0];
    n   = (leds_in_use < MAX_LEDS) ? leds_in_use : LEDS_W'(MAX_LEDS);
    case (op)
      CMD_SET: begin
        if (!frame_on && idx < n) begin
          colors[idx] = {payload[15:8], payload[23:16], payload[31:24]};
          w.accepted  = 1'b1;
        end
      end
      CMD_START: begin
        if (!frame_on) begin
          w.accepted = 1'b1;
          stop_frame();
          if (n != 0 || latch_words != 0) begin
            frame_on = 1'b1;
            tail_on  = (n == 0);
          end
        end
      end
      CMD_TICK: begin
        if (frame_on) begin
          w.word_valid = 1'b1;
          if (!tail_on && led_at < n) begin
            bit_val = colors[led_at][TOP_BIT - bit_at];
            w.compare_value = bit_val ? one_code : zero_code;
            bit_at = bit_at + 1'b1;
            if (bit_at >= BITS_PER_LED) begin
              bit_at = '0;
              led_at = led_at + 1'b1;
            end
            if (led_at >= n) begin
              if (latch_words == 0) begin
                w.frame_last = 1'b1;
                stop_frame();
              end else begin
                tail_on    = 1'b1;
                tail_count = '0;
              end
            end
          end else begin
            // latch tail: zero words until the count is reached
            tail_on    = 1'b1;
            tail_count = tail_count + 1'b1;
            if (tail_count >= latch_words) begin
              w.frame_last = 1'b1;
              stop_frame();
            end
          end
        end
      end
      default: ;
    endcase
    w.busy = frame_on;
    return w;
  endfunction

  function automatic void check_field(string field, int exp_v, int act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    led_word_t w;
    if (rst) begin
      for (int i = 0; i < MAX_LEDS; i++) colors[i] = '0;
      stop_frame();
      one_code    = '0;
      zero_code   = '0;
      latch_words = LATCH_WORDS_RST;
      leds_in_use = LEDS_IN_USE_RST;
      expected_words.delete();
      fail_count  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %0h last %0b user %0h",
                   $time, m_tdata, m_tlast, m_tuser);
        end else begin
          w = expected_words.pop_front();
          check_field("compare_value", w.compare_value, m_tdata);
          check_field("word_valid", w.word_valid, m_tuser[0]);
          check_field("frame_last", w.frame_last, m_tlast);
          check_field("busy_res", w.busy, m_tuser[1]);
          check_field("accepted", w.accepted, m_tuser[2]);
        end
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_ONE_CODE:    one_code    = cfg_data[CODE_W-1:0];
          REG_ZERO_CODE:   zero_code   = cfg_data[CODE_W-1:0];
          REG_LATCH_WORDS: latch_words = cfg_data[LATCH_W-1:0];
          REG_LEDS_IN_USE: leds_in_use = cfg_data[LEDS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_words.push_back(encode_item(cmd_t'(s_tuser), s_tdata));
    end
    pending = expected_words.size();
  end

endmodule

[sim/testbench.sv]
// testbench top for the rgb led chain bit encoder: stimulus, handshake idling and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rlbe_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 190;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_NONE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ONE_CODE;
  logic [CFG_W-1:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_asked = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int items_sent = 0;
  int stuck_cycles = 0;

  rgb_led_chain_bit_encoder_unit dut (.*);
  rlbe_checker word_check (.*);

  initial forever #5 clk = ~clk;

  // receiver: random stalls plus one long hold-off on request
  initial forever begin
    @(negedge clk);
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_item(input cmd_t op, input logic [31:0] payload);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= payload;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_color(input int idx);
    logic [31:0] payload;
    payload      = $urandom;
    payload[7:0] = idx[7:0];
    send_item(CMD_SET, payload);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [CODE_W-1:0] one, input logic [CODE_W-1:0] zero,
                            input logic [LATCH_W-1:0] lat, input logic [LEDS_W-1:0] leds);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ONE_CODE;
    cfg_data  <= one;
    @(negedge clk);
    cfg_index <= REG_ZERO_CODE;
    cfg_data  <= zero;
    @(negedge clk);
    cfg_index <= REG_LATCH_WORDS;
    cfg_data  <= CFG_W'(lat);
    @(negedge clk);
    cfg_index <= REG_LEDS_IN_USE;
    cfg_data  <= CFG_W'(leds);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ticks for one frame, with refused set/start items and unused commands mixed in
  task automatic run_frame(input int ticks, input int noise_pct);
    cmd_t noise_op;
    for (int k = 0; k < ticks; k++) begin
      if ($urandom_range(99) < noise_pct) begin
        case ($urandom_range(2))
          0: noise_op = CMD_SET;
          1: noise_op = CMD_START;
          default: noise_op = CMD_NONE;
        endcase
        send_item(noise_op, $urandom);
      end
      send_item(CMD_TICK, $urandom);
    end
  endtask

  function automatic int frame_ticks(input int leds, input int lat);
    int n;
    n = (leds < 64) ? leds : 64;
    return (n == 0 && lat == 0) ? 0 : 24 * n + lat;
  endfunction

  task automatic run_session(input bit squeeze);
    int leds;
    int lat;
    int n;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) leds = 0;
    else if (pick < 90) leds = $urandom_range(1, 3);
    else leds = $urandom_range(4, 8);
    lat = ($urandom_range(99) < 20) ? 0 : $urandom_range(1, 8);
    n = leds;
    set_config(CODE_W'($urandom_range(0, 65535)), CODE_W'($urandom_range(0, 65535)),
               LATCH_W'(lat), LEDS_W'(leds));
    if (squeeze) hold_asked++;
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(9) < 8 && n > 0) send_color($urandom_range(0, n - 1));
      else send_color($urandom_range(0, 255));
    end
    if ($urandom_range(3) == 0) send_item(CMD_TICK, $urandom);
    send_item(CMD_START, $urandom);
    run_frame(frame_ticks(leds, lat), 8);
    if ($urandom_range(2) == 0) send_item(CMD_TICK, $urandom);
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    int goal;
    idle_tab  = '{0, 58, 0, 30};
    stall_tab = '{0, 0, 58, 30};
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // registers at reset values
    send_item(CMD_NONE, $urandom);
    send_item(CMD_TICK, $urandom);
    send_item(CMD_SET, {8'hFF, 8'hFF, 8'hFF, 8'd63});
    send_item(CMD_SET, {8'hFF, 8'hFF, 8'hFF, 8'd64});

    // single led, no latch tail
    set_config(16'hFFFF, 16'h0000, 10'd0, 7'd1);
    send_item(CMD_SET, {8'hA5, 8'h00, 8'hFF, 8'd0});
    send_item(CMD_SET, {8'h00, 8'h00, 8'h00, 8'd1});
    send_item(CMD_SET, {8'h00, 8'h00, 8'h00, 8'd255});
    send_item(CMD_START, 32'h0);
    send_item(CMD_SET, {8'h00, 8'h00, 8'h00, 8'd0});
    send_item(CMD_START, 32'hFFFF_FFFF);
    send_item(CMD_NONE, 32'hFFFF_FFFF);
    run_frame(24, 0);
    send_item(CMD_TICK, 32'h0);

    // empty frame
    set_config(16'h0001, 16'hFFFE, 10'd0, 7'd0);
    send_item(CMD_START, $urandom);
    send_item(CMD_TICK, $urandom);

    // zero count, tail only
    set_config(16'h1234, 16'h00FF, 10'd3, 7'd0);
    send_item(CMD_START, $urandom);
    run_frame(3, 0);
    send_item(CMD_TICK, $urandom);

    // count above the store, then the count and tail shrunk mid-frame
    set_config(CODE_W'($urandom_range(0, 65535)), CODE_W'($urandom_range(0, 65535)),
               10'd1023, 7'd127);
    send_color(63);
    send_color(64);
    send_color(127);
    send_item(CMD_START, $urandom);
    run_frame(30, 0);
    set_config(CODE_W'($urandom_range(0, 65535)), CODE_W'($urandom_range(0, 65535)),
               10'd3, 7'd1);
    run_frame(3, 0);
    send_item(CMD_TICK, $urandom);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_tab[ph];
      sink_stall_pct = stall_tab[ph];
      goal = items_sent + PHASE_ITEMS;
      run_session(ph == 0);
      while (items_sent < goal) run_session(1'b0);
    end

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
